// ===== design/ssaf_pkg.sv =====
package ssaf_pkg;

  localparam int MAX_WINDOW = 22;
  localparam int SAMPLE_W   = 8;
  localparam int WIN_W      = 5;
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int TOTAL_W    = 13;
  localparam int LEVEL_W    = 4;
  localparam int RECIP_W    = 9;
  localparam int SUM_W      = 12;
  localparam int RAM_W      = 2 * SAMPLE_W;
  localparam int CFG_AW     = 4;
  localparam int CFG_DW     = 32;

  localparam logic [1:0] REG_WINDOW     = 2'd0;
  localparam logic [1:0] REG_X_STRENGTH = 2'd1;
  localparam logic [1:0] REG_Y_STRENGTH = 2'd2;

  localparam logic [WIN_W-1:0]   WINDOW_RESET   = WIN_W'(MAX_WINDOW);
  localparam logic [LEVEL_W-1:0] STRENGTH_RESET = '0;

  // 256 / window, index is the effective window length
  localparam logic [RECIP_W-1:0] RECIP_TAB [0:MAX_WINDOW] = '{
    9'd0,   9'd256, 9'd128, 9'd85, 9'd64, 9'd51, 9'd43, 9'd37,
    9'd32,  9'd28,  9'd25,  9'd23, 9'd21, 9'd20, 9'd18, 9'd17,
    9'd16,  9'd15,  9'd14,  9'd13, 9'd13, 9'd12, 9'd11
  };

  typedef struct packed {
    logic [WIN_W-1:0]   window_length;
    logic [LEVEL_W-1:0] x_strength;
    logic [LEVEL_W-1:0] y_strength;
  } ssaf_cfg_t;

  typedef struct packed {
    logic load_in;
    logic fill_wr;
    logic rd_req;
    logic upd;
    logic avg;
    logic blend;
    logic product;
    logic prime_out;
    logic out_load;
  } ssaf_cmd_t;

  typedef struct packed {
    logic primed;
    logic fill_last;
  } ssaf_sts_t;

  function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] w);
    logic [WIN_W-1:0] r;
    if (w == '0) begin
      r = WIN_W'(1);
    end else if (w > WIN_W'(MAX_WINDOW)) begin
      r = WIN_W'(MAX_WINDOW);
    end else begin
      r = w;
    end
    return r;
  endfunction

endpackage

// ===== design/ssaf_in_if.sv =====
interface ssaf_in_if;
  logic                          valid;
  logic                          ready;
  logic [ssaf_pkg::SAMPLE_W-1:0] x_sample;
  logic [ssaf_pkg::SAMPLE_W-1:0] y_sample;

  modport source (output valid, output x_sample, output y_sample, input ready);
  modport sink   (input valid, input x_sample, input y_sample, output ready);
endinterface

// ===== design/ssaf_out_if.sv =====
interface ssaf_out_if;
  logic                          valid;
  logic                          ready;
  logic [ssaf_pkg::SAMPLE_W-1:0] x_out;
  logic [ssaf_pkg::SAMPLE_W-1:0] y_out;
  logic                          priming;

  modport source (output valid, output x_out, output y_out, output priming, input ready);
  modport sink   (input valid, input x_out, input y_out, input priming, output ready);
endinterface

// ===== design/ssaf_ram.sv =====
module ssaf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 22,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/ssaf_ctrl.sv =====
module ssaf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ssaf_pkg::ssaf_sts_t sts,
  output ssaf_pkg::ssaf_cmd_t cmd
);

  typedef enum logic [2:0] {
    IDLE, FILL, READ, UPDATE, AVERAGE, BLEND, PRODUCT, DELIVER
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   prime_r, prime_nxt;

  always_comb begin
    state_nxt = state_r;
    prime_nxt = prime_r;
    cmd       = '0;
    cmd.prime_out = prime_r;
    unique case (state_r)
      IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          prime_nxt   = !sts.primed;
          state_nxt   = sts.primed ? READ : FILL;
        end
      end
      FILL: begin
        cmd.fill_wr = 1'b1;
        if (sts.fill_last) begin
          state_nxt = DELIVER;
        end
      end
      READ: begin
        cmd.rd_req = 1'b1;
        state_nxt  = UPDATE;
      end
      UPDATE: begin
        cmd.upd   = 1'b1;
        state_nxt = AVERAGE;
      end
      AVERAGE: begin
        cmd.avg   = 1'b1;
        state_nxt = BLEND;
      end
      BLEND: begin
        cmd.blend = 1'b1;
        state_nxt = PRODUCT;
      end
      PRODUCT: begin
        cmd.product = 1'b1;
        state_nxt   = DELIVER;
      end
      DELIVER: begin
        // wait for the output register to drain
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
      prime_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      prime_r     <= prime_nxt;
    end
  end

  assign in_ready  = (state_r == IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_fill_only_unprimed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill_wr |-> !sts.primed)
    else $error("ring fill while already primed");

  a_read_then_update: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == READ |=> state_r == UPDATE)
    else $error("ring read not followed by total update");

  a_primed_request_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && sts.primed) |=> state_r == READ)
    else $error("primed request did not start a ring read");

  a_load_frees_output: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.out_load)
    else $error("output overwritten while stalled");
`endif

endmodule

// ===== design/ssaf_datapath.sv =====
module ssaf_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ssaf_pkg::ssaf_cmd_t                 cmd,
  input  ssaf_pkg::ssaf_cfg_t                 cfg,
  input  logic [ssaf_pkg::SAMPLE_W-1:0]       in_x,
  input  logic [ssaf_pkg::SAMPLE_W-1:0]       in_y,
  output ssaf_pkg::ssaf_sts_t                 sts,
  output logic [ssaf_pkg::SAMPLE_W-1:0]       out_x,
  output logic [ssaf_pkg::SAMPLE_W-1:0]       out_y,
  output logic                                out_priming
);

  localparam int SW = ssaf_pkg::SAMPLE_W;
  localparam int TW = ssaf_pkg::TOTAL_W;
  localparam int RW = ssaf_pkg::RECIP_W;
  localparam int UW = ssaf_pkg::SUM_W;
  localparam int AW = ssaf_pkg::SLOT_W;
  localparam int WW = ssaf_pkg::WIN_W;
  localparam int PW = TW + RW;
  localparam int BW = UW + RW;
  localparam logic [SW-1:0] CENTER_LO = SW'(126);
  localparam logic [SW-1:0] CENTER_HI = SW'(128);

  function automatic logic [UW-1:0] blend_sum(input logic [SW-1:0] s,
                                               input logic [SW-1:0] a,
                                               input logic [ssaf_pkg::LEVEL_W-1:0] level);
    logic [UW-1:0] s12;
    logic [UW-1:0] a12;
    logic [UW-1:0] r;
    s12 = UW'(s);
    a12 = UW'(a);
    case (level) inside
      4'd1:    r = (s12 << 3) + a12;
      4'd2:    r = (s12 << 2) + s12 + a12;
      4'd3:    r = (s12 << 1) + s12 + a12;
      4'd4:    r = (s12 << 1) + (s12 >> 1) + a12;
      4'd5:    r = (s12 << 1) + a12;
      4'd6:    r = s12 + (s12 >> 1) + a12;
      4'd7:    r = s12 + a12;
      4'd8:    r = a12 + (a12 >> 1) + s12;
      4'd9:    r = (a12 << 1) + s12;
      4'd10:   r = (a12 << 1) + (a12 >> 1) + s12;
      4'd11:   r = (a12 << 1) + a12 + s12;
      4'd12:   r = (a12 << 2) + a12 + s12;
      4'd13:   r = (a12 << 3) + s12;
      4'd14:   r = a12;
      default: r = s12;
    endcase
    return r;
  endfunction

  // the shift-by-2 and halving levels become *64 and *128 ahead of the common >> 8
  function automatic logic [RW-1:0] blend_k(input logic [ssaf_pkg::LEVEL_W-1:0] level);
    logic [RW-1:0] k;
    case (level) inside
      4'd1, 4'd13:  k = RW'(28);
      4'd2, 4'd12:  k = RW'(42);
      4'd3, 4'd11:  k = RW'(64);
      4'd4, 4'd10:  k = RW'(73);
      4'd5, 4'd9:   k = RW'(85);
      4'd6, 4'd8:   k = RW'(102);
      4'd7:         k = RW'(128);
      default:      k = RW'(256);
    endcase
    return k;
  endfunction

  logic [SW-1:0] xs_r, ys_r;
  logic [AW-1:0] fill_cnt_r, oldest_r;
  logic          primed_r;
  logic [TW-1:0] x_total_r, y_total_r;
  logic [SW-1:0] x_avg_r, y_avg_r;
  logic [UW-1:0] x_sum_r, y_sum_r;
  logic [RW-1:0] x_k_r, y_k_r;
  logic [SW-1:0] x_res_r, y_res_r;
  logic [SW-1:0] x_out_r, y_out_r;
  logic          priming_r;

  logic [WW-1:0]                  win;
  logic [WW-1:0]                  win_m1;
  logic [ssaf_pkg::RAM_W-1:0]     ram_rdata;
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [SW-1:0]                  old_x, old_y;
  logic [AW:0]                    slot_inc;
  logic [RW-1:0]                  recip;
  logic [PW-1:0]                  x_prod, y_prod;
  logic [BW-1:0]                  x_bprod, y_bprod;
  logic                           x_center, y_center;

  assign win    = ssaf_pkg::eff_window(cfg.window_length);
  assign win_m1 = win - WW'(1);
  assign recip  = ssaf_pkg::RECIP_TAB[win];

  assign ram_we    = cmd.fill_wr || cmd.upd;
  assign ram_waddr = cmd.fill_wr ? fill_cnt_r : oldest_r;

  ssaf_ram #(
    .WIDTH (ssaf_pkg::RAM_W),
    .DEPTH (ssaf_pkg::MAX_WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data ({xs_r, ys_r}),
    .rd_en   (cmd.rd_req),
    .rd_addr (oldest_r),
    .rd_data (ram_rdata)
  );

  assign old_x    = ram_rdata[ssaf_pkg::RAM_W-1:SW];
  assign old_y    = ram_rdata[SW-1:0];
  assign slot_inc = {1'b0, oldest_r} + (AW+1)'(1);

  assign x_prod  = PW'(x_total_r) * PW'(recip);
  assign y_prod  = PW'(y_total_r) * PW'(recip);
  assign x_bprod = BW'(x_sum_r) * BW'(x_k_r);
  assign y_bprod = BW'(y_sum_r) * BW'(y_k_r);

  assign x_center = (xs_r >= CENTER_LO) && (xs_r <= CENTER_HI);
  assign y_center = (ys_r >= CENTER_LO) && (ys_r <= CENTER_HI);

  assign sts.primed    = primed_r;
  assign sts.fill_last = ({{(WW-AW){1'b0}}, fill_cnt_r} == win_m1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r  <= 1'b0;
      oldest_r  <= '0;
      x_total_r <= '0;
      y_total_r <= '0;
    end else begin
      if (cmd.fill_wr && sts.fill_last) begin
        primed_r  <= 1'b1;
        oldest_r  <= '0;
        x_total_r <= TW'(win) * TW'(xs_r);
        y_total_r <= TW'(win) * TW'(ys_r);
      end
      if (cmd.upd) begin
        x_total_r <= x_total_r - TW'(old_x) + TW'(xs_r);
        y_total_r <= y_total_r - TW'(old_y) + TW'(ys_r);
        // wrap once past the window end
        if (slot_inc >= (AW+1)'(win)) begin
          oldest_r <= '0;
        end else begin
          oldest_r <= slot_inc[AW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      xs_r       <= in_x;
      ys_r       <= in_y;
      fill_cnt_r <= '0;
    end
    if (cmd.fill_wr) begin
      fill_cnt_r <= fill_cnt_r + AW'(1);
    end
    if (cmd.avg) begin
      x_avg_r <= x_prod[2*SW-1:SW];
      y_avg_r <= y_prod[2*SW-1:SW];
    end
    if (cmd.blend) begin
      x_sum_r <= blend_sum(xs_r, x_avg_r, cfg.x_strength);
      y_sum_r <= blend_sum(ys_r, y_avg_r, cfg.y_strength);
      x_k_r   <= blend_k(cfg.x_strength);
      y_k_r   <= blend_k(cfg.y_strength);
    end
    if (cmd.product) begin
      x_res_r <= x_center ? xs_r : x_bprod[2*SW-1:SW];
      y_res_r <= y_center ? ys_r : y_bprod[2*SW-1:SW];
    end
    if (cmd.out_load) begin
      x_out_r   <= cmd.prime_out ? xs_r : x_res_r;
      y_out_r   <= cmd.prime_out ? ys_r : y_res_r;
      priming_r <= cmd.prime_out;
    end
  end

  assign out_x       = x_out_r;
  assign out_y       = y_out_r;
  assign out_priming = priming_r;

`ifndef SYNTH
  a_oldest_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    oldest_r < AW'(ssaf_pkg::MAX_WINDOW))
    else $error("oldest slot pointer beyond ring");

  a_prime_resets_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fill_wr && sts.fill_last) |=> (primed_r && oldest_r == '0))
    else $error("priming did not leave slot pointer at zero");
`endif

endmodule

// ===== design/stick_snapback_average_filter.sv =====
// Stick snapback averaging filter.
// in_ch carries one X/Y stick sample pair per request (valid/ready); out_ch
// returns one filtered pair per request, with priming set on the first one
// after reset. Registers over the APB port: 0x0 window length (1..22, 0 acts
// as 1), 0x4 X blend strength, 0x8 Y blend strength (0 raw .. 14 average).
// Write them only while no request is in flight.
// A primed request runs the ring RAM read, the total update and the two
// multiply stages (average, then fader) one after another on a single
// item; the block accepts no new request until that item is loaded
// into the output register. The first request after reset instead fills
// the ring, one slot per cycle.
// The result sits in an output register; the block still accepts the next
// request while that register waits, and only holds its finished result
// until the receiver takes the previous one.
// Reset (rst_n low, synchronous) clears totals, slot pointer and the primed
// flag, drops out valid and restores the register defaults; the ring RAM is
// not cleared, as priming overwrites every slot in use.
module stick_snapback_average_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  ssaf_in_if.sink                       in_ch,
  ssaf_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssaf_pkg::CFG_AW-1:0]   paddr,
  input  logic [ssaf_pkg::CFG_DW-1:0]   pwdata,
  output logic [ssaf_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int DW = ssaf_pkg::CFG_DW;
  localparam int WW = ssaf_pkg::WIN_W;
  localparam int LW = ssaf_pkg::LEVEL_W;

  ssaf_pkg::ssaf_cfg_t cfg_r;
  ssaf_pkg::ssaf_cmd_t cmd;
  ssaf_pkg::ssaf_sts_t sts;
  logic                cfg_wr;
  logic [1:0]          reg_idx;
  logic                in_ready;
  logic                out_valid;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_length <= ssaf_pkg::WINDOW_RESET;
      cfg_r.x_strength    <= ssaf_pkg::STRENGTH_RESET;
      cfg_r.y_strength    <= ssaf_pkg::STRENGTH_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        ssaf_pkg::REG_WINDOW:     cfg_r.window_length <= pwdata[WW-1:0];
        ssaf_pkg::REG_X_STRENGTH: cfg_r.x_strength    <= pwdata[LW-1:0];
        ssaf_pkg::REG_Y_STRENGTH: cfg_r.y_strength    <= pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ssaf_pkg::REG_WINDOW:     prdata = DW'(cfg_r.window_length);
      ssaf_pkg::REG_X_STRENGTH: prdata = DW'(cfg_r.x_strength);
      ssaf_pkg::REG_Y_STRENGTH: prdata = DW'(cfg_r.y_strength);
      default:                  prdata = '0;
    endcase
  end

  ssaf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ssaf_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg         (cfg_r),
    .in_x        (in_ch.x_sample),
    .in_y        (in_ch.y_sample),
    .sts         (sts),
    .out_x       (out_ch.x_out),
    .out_y       (out_ch.y_out),
    .out_priming (out_ch.priming)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule
